// ===== rtl/particle_pool_integrator_top_defines.svh =====
// Assertion macros for the particle pool integrator.
`ifndef PARTICLE_POOL_INTEGRATOR_TOP_DEFINES_SVH
`define PARTICLE_POOL_INTEGRATOR_TOP_DEFINES_SVH

// Check under reset gating.
`define PPI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check at every edge.
`define PPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/ppi_pkg.sv =====
`default_nettype none
package ppi_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int DIV_W     = 24;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        FN_EMIT   = 2'd0,
        FN_TICK   = 2'd1,
        FN_RENDER = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_MUL_G,
        S_ADD_G,
        S_MUL_X,
        S_ADD_X,
        S_MUL_Y,
        S_ADD_Y,
        S_WB,
        S_MUL_A,
        S_DIV_A,
        S_MUL_S,
        S_DIV_S,
        S_PUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        life;
        logic [15:0]        full_life;
        logic [7:0]         size;
        logic signed [15:0] gravity;
        logic [31:0]        colour;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [11:0] edge_of(input logic signed [15:0] q,
                                                   input logic [2:0] half);
        logic signed [16:0] d;
        logic signed [16:0] nd;
        logic signed [16:0] w;
        logic signed [11:0] r;
        d  = {q[15], q} - $signed({10'd0, half, 4'd0});
        nd = -d;
        if (!d[16]) begin
            w = d >>> 4;
        end else begin
            w = -(nd >>> 4);
        end
        if (w > 17'sd2047) begin
            r = 12'sh7ff;
        end else if (w < -17'sd2048) begin
            r = 12'sh800;
        end else begin
            r = w[11:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ppi_ram.sv =====
`default_nettype none
module ppi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ppi_div.sv =====
`default_nettype none
module ppi_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ppi_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [15:0]               i_divisor,
    output logic      [ppi_pkg::DIV_W-1:0] o_quot,
    output ppi_pkg::t_div_stat             o_stat
);
    import ppi_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [16:0]          r_rem;
    logic [DIV_W-1:0]     r_dq;
    logic [16:0]          sh;
    logic [17:0]          diff;
    logic                 ge;
    logic [16:0]          n_rem;

    always_comb begin
        sh    = {r_rem[15:0], r_dq[DIV_W-1]};
        diff  = {1'b0, sh} - {2'b0, i_divisor};
        ge    = !diff[17];
        n_rem = ge ? diff[16:0] : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[DIV_W-2:0], ge};
        end
    end

    assign o_quot      = r_dq;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
`default_nettype wire

// ===== rtl/particle_pool_integrator_top.sv =====
// Particle pool integrator.
// Request channel: i_valid/o_stall with i_func and the emit and tick fields.
// A request is taken when i_valid is high and o_stall is low; o_stall is low
// only while the block is idle, so it works on one request at a time.
// Emit and clear finish in the accepting cycle. Tick walks the pool slot by
// slot; for each live particle it loads the slot, uses one multiplier three
// times and writes the slot back through the write port of the slot memory;
// a particle whose life runs out is retired instead.
// Render walks the pool the same way and yields one square per live particle
// on o_valid/i_stall, with o_last set on the final square; for a nonzero
// full_life the bit-serial divider runs twice (alpha and side) at one quotient
// bit per cycle. No square is produced when no particle is live.
// The square sits in an output register; while i_stall holds it, the walk
// pauses before loading the next square.
// Reset clears the live flags, the emit pointer and the output valid; slot
// contents are left as they are.
`default_nettype none
`include "particle_pool_integrator_top_defines.svh"
module particle_pool_integrator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic signed [15:0] i_vel_x,
    input  wire logic signed [15:0] i_vel_y,
    input  wire logic [15:0]        i_life_time,
    input  wire logic [7:0]         i_dot_size,
    input  wire logic signed [15:0] i_fall_accel,
    input  wire logic [31:0]        i_colour_rgba,
    input  wire logic [15:0]        i_time_step,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [11:0]      o_rect_x,
    output logic signed [11:0]      o_rect_y,
    output logic [3:0]              o_rect_side,
    output logic [7:0]              o_red,
    output logic [7:0]              o_green,
    output logic [7:0]              o_blue,
    output logic [7:0]              o_faded_alpha,
    output logic                    o_last
);
    import ppi_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_next;
    logic [POOL_SIZE-1:0]  r_active;
    logic                  r_tick;
    logic [15:0]           r_dt;
    t_slot                 r_slot;
    logic signed [33:0]    r_prod;
    logic [7:0]            r_alpha;
    logic [3:0]            r_side;

    logic                  r_ovalid;
    logic signed [11:0]    r_rect_x;
    logic signed [11:0]    r_rect_y;
    logic [3:0]            r_rect_side;
    logic [31:0]           r_col;
    logic [7:0]            r_falpha;
    logic                  r_last;

    logic                  in_acc;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_slot                 ram_wdata;
    t_slot                 ram_rdata;
    t_slot                 load_slot;
    logic                  idx_inc;
    logic                  retire;
    logic                  div_start;
    logic                  out_load;
    logic                  at_end;
    logic                  cur_active;
    logic [POOL_SIZE-1:0]  above;
    logic                  none_above;
    logic signed [16:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic signed [33:0]    mul_p;
    logic signed [20:0]    add_sum;
    logic [DIV_W-1:0]      div_q;
    t_div_stat             div_st;
    logic [DIV_W-5:0]      side_q;

    assign in_acc     = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign at_end     = (r_idx == CNT_W'(POOL_SIZE));
    assign cur_active = r_active[r_idx[IDX_W-1:0]];

    always_comb begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            above[i] = (CNT_W'(i) > r_idx);
        end
        none_above = ~|(r_active & above);
    end

    ppi_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(POOL_SIZE)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        load_slot = ram_rdata;
        if (r_tick) begin
            load_slot.life = ram_rdata.life - r_dt;
        end
    end

    always_comb begin
        unique case (r_state)
            S_MUL_G: mul_a = {r_slot.gravity[15], r_slot.gravity};
            S_MUL_X: mul_a = {r_slot.vel_x[15], r_slot.vel_x};
            S_MUL_Y: mul_a = {r_slot.vel_y[15], r_slot.vel_y};
            default: mul_a = $signed({1'b0, r_slot.life});
        endcase
        unique case (r_state)
            S_MUL_A: mul_b = $signed({9'd0, r_slot.colour[7:0]});
            S_MUL_S: mul_b = $signed({9'd0, r_slot.size});
            default: mul_b = $signed({1'b0, r_dt});
        endcase
        mul_p = mul_a * mul_b;
        unique case (r_state)
            S_ADD_G: add_sum = {{5{r_slot.vel_y[15]}}, r_slot.vel_y};
            S_ADD_X: add_sum = {{5{r_slot.pos_x[15]}}, r_slot.pos_x};
            default: add_sum = {{5{r_slot.pos_y[15]}}, r_slot.pos_y};
        endcase
        add_sum = add_sum + {r_prod[33], r_prod[33:14]};
    end

    ppi_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(mul_p[DIV_W-1:0]),
        .i_divisor (r_slot.full_life),
        .o_quot    (div_q),
        .o_stat    (div_st)
    );

    assign side_q = div_q[DIV_W-1:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_wdata = r_slot;
        idx_inc   = 1'b0;
        retire    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && t_func'(i_func) == FN_EMIT) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_next;
                    ram_wdata = '{pos_x: i_pos_x, pos_y: i_pos_y, vel_x: i_vel_x,
                                  vel_y: i_vel_y, life: i_life_time,
                                  full_life: i_life_time, size: i_dot_size,
                                  gravity: i_fall_accel, colour: i_colour_rgba};
                end else if (in_acc && (t_func'(i_func) == FN_TICK ||
                                        t_func'(i_func) == FN_RENDER)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (at_end) begin
                    n_state = S_IDLE;
                end else if (cur_active) begin
                    n_state = S_LOAD;
                end else begin
                    idx_inc = 1'b1;
                end
            end
            S_LOAD: begin
                if (r_tick) begin
                    if (ram_rdata.life <= r_dt) begin
                        retire  = 1'b1;
                        idx_inc = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MUL_G;
                    end
                end else if (ram_rdata.full_life == 16'd0) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_G: n_state = S_ADD_G;
            S_ADD_G: n_state = S_MUL_X;
            S_MUL_X: n_state = S_ADD_X;
            S_ADD_X: n_state = S_MUL_Y;
            S_MUL_Y: n_state = S_ADD_Y;
            S_ADD_Y: n_state = S_WB;
            S_WB: begin
                ram_we  = 1'b1;
                idx_inc = 1'b1;
                n_state = S_SCAN;
            end
            S_MUL_A: begin
                div_start = 1'b1;
                n_state   = S_DIV_A;
            end
            S_DIV_A: begin
                if (div_st.done) begin
                    n_state = S_MUL_S;
                end
            end
            S_MUL_S: begin
                div_start = 1'b1;
                n_state   = S_DIV_S;
            end
            S_DIV_S: begin
                if (div_st.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_ovalid || !i_stall) begin
                    out_load = 1'b1;
                    idx_inc  = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_next   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc && r_state == S_IDLE) begin
                r_idx <= '0;
                unique case (t_func'(i_func))
                    FN_EMIT: begin
                        r_active[r_next] <= 1'b1;
                        r_next <= (r_next == IDX_W'(POOL_SIZE - 1)) ? '0 : r_next + 1'b1;
                    end
                    FN_CLEAR: r_active <= '0;
                    default: ;
                endcase
            end
            if (retire) begin
                r_active[r_idx[IDX_W-1:0]] <= 1'b0;
            end
            if (idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tick <= (t_func'(i_func) == FN_TICK);
            r_dt   <= i_time_step;
        end
        if (r_state == S_LOAD) begin
            r_slot  <= load_slot;
            r_alpha <= 8'd0;
            r_side  <= 4'd1;
        end
        if (r_state == S_MUL_G || r_state == S_MUL_X || r_state == S_MUL_Y) begin
            r_prod <= mul_p;
        end
        if (r_state == S_ADD_G) begin
            r_slot.vel_y <= sat16(add_sum);
        end
        if (r_state == S_ADD_X) begin
            r_slot.pos_x <= sat16(add_sum);
        end
        if (r_state == S_ADD_Y) begin
            r_slot.pos_y <= sat16(add_sum);
        end
        if (r_state == S_DIV_A && div_st.done) begin
            r_alpha <= (div_q > DIV_W'(255)) ? 8'd255 : div_q[7:0];
        end
        if (r_state == S_DIV_S && div_st.done) begin
            if (side_q == '0) begin
                r_side <= 4'd1;
            end else if (side_q > (DIV_W-4)'(15)) begin
                r_side <= 4'd15;
            end else begin
                r_side <= side_q[3:0];
            end
        end
        if (out_load) begin
            r_rect_x    <= edge_of(r_slot.pos_x, r_side[3:1]);
            r_rect_y    <= edge_of(r_slot.pos_y, r_side[3:1]);
            r_rect_side <= r_side;
            r_col       <= r_slot.colour;
            r_falpha    <= r_alpha;
            r_last      <= none_above;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_rect_x      = r_rect_x;
    assign o_rect_y      = r_rect_y;
    assign o_rect_side   = r_rect_side;
    assign o_red         = r_col[31:24];
    assign o_green       = r_col[23:16];
    assign o_blue        = r_col[15:8];
    assign o_faded_alpha = r_falpha;
    assign o_last        = r_last;

    `PPI_ASSERT_RST(a_side_nonzero, o_valid |-> (o_rect_side != 4'd0), "square side of zero")
    `PPI_ASSERT_RST(a_div_phase, div_st.busy |-> (r_state == S_DIV_A || r_state == S_DIV_S), "divider busy outside divide phase")
    `PPI_ASSERT_RST(a_ram_write, ram_we |-> (r_state == S_IDLE || r_state == S_WB), "slot write outside emit or write back")
    `PPI_ASSERT_RST(a_tick_start, (in_acc && t_func'(i_func) == FN_TICK) |=> (r_state == S_SCAN), "tick did not start walk")
endmodule
`default_nettype wire

// ===== test/tb_particle_pool_integrator_top.sv =====
`default_nettype none
module tb_particle_pool_integrator_top;
    import ppi_pkg::*;

    typedef struct packed {
        logic signed [11:0] rect_x;
        logic signed [11:0] rect_y;
        logic [3:0]         rect_side;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         faded_alpha;
        logic               last;
    } t_square;

    typedef struct {
        t_func              func;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [15:0]        life_time;
        logic [7:0]         dot_size;
        logic signed [15:0] fall_accel;
        logic [31:0]        colour;
        logic [15:0]        time_step;
    } t_request;

    class particle_scoreboard;
        t_slot    pool[POOL_SIZE];
        bit       live[POOL_SIZE];
        int       emit_ptr;
        t_square  pending_squares[$];
        int       mismatches;
        int       squares_seen;

        function new();
            emit_ptr = 0;
            mismatches = 0;
            squares_seen = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        static function logic signed [15:0] clamp16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        static function longint step_q14(longint v);
            return v >>> 14;
        endfunction

        static function logic signed [11:0] left_edge(logic signed [15:0] q, int half);
            int d;
            int w;
            d = int'(q) - half * 16;
            w = (d >= 0) ? d / 16 : -((-d) / 16);
            if (w > 2047) w = 2047;
            if (w < -2048) w = -2048;
            return w[11:0];
        endfunction

        function void note_request(t_request r);
            longint dt;
            longint lf;
            longint fl;
            int alpha;
            int side;
            t_square sq;
            int n;
            case (r.func)
                FN_EMIT: begin
                    pool[emit_ptr].pos_x = r.pos_x;
                    pool[emit_ptr].pos_y = r.pos_y;
                    pool[emit_ptr].vel_x = r.vel_x;
                    pool[emit_ptr].vel_y = r.vel_y;
                    pool[emit_ptr].life = r.life_time;
                    pool[emit_ptr].full_life = r.life_time;
                    pool[emit_ptr].size = r.dot_size;
                    pool[emit_ptr].gravity = r.fall_accel;
                    pool[emit_ptr].colour = r.colour;
                    live[emit_ptr] = 1;
                    emit_ptr = (emit_ptr + 1) % POOL_SIZE;
                end
                FN_TICK: begin
                    dt = r.time_step;
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        if (!live[i]) continue;
                        if (pool[i].life <= dt) begin
                            live[i] = 0;
                            continue;
                        end
                        pool[i].life = pool[i].life - r.time_step;
                        pool[i].vel_y = clamp16(longint'(pool[i].vel_y)
                            + step_q14(longint'(pool[i].gravity) * dt));
                        pool[i].pos_x = clamp16(longint'(pool[i].pos_x)
                            + step_q14(longint'(pool[i].vel_x) * dt));
                        pool[i].pos_y = clamp16(longint'(pool[i].pos_y)
                            + step_q14(longint'(pool[i].vel_y) * dt));
                    end
                end
                FN_RENDER: begin
                    n = 0;
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        if (!live[i]) continue;
                        if (pool[i].full_life == 0) begin
                            alpha = 0;
                            side = 1;
                        end else begin
                            lf = pool[i].life;
                            fl = pool[i].full_life;
                            alpha = int'((lf * pool[i].colour[7:0]) / fl);
                            side = int'((lf * pool[i].size) / (fl * 16));
                            if (side < 1) side = 1;
                            if (side > 15) side = 15;
                            if (alpha > 255) alpha = 255;
                        end
                        sq.rect_x = left_edge(pool[i].pos_x, side / 2);
                        sq.rect_y = left_edge(pool[i].pos_y, side / 2);
                        sq.rect_side = side[3:0];
                        sq.red = pool[i].colour[31:24];
                        sq.green = pool[i].colour[23:16];
                        sq.blue = pool[i].colour[15:8];
                        sq.faded_alpha = alpha[7:0];
                        sq.last = 0;
                        pending_squares.push_back(sq);
                        n++;
                    end
                    if (n > 0) pending_squares[$].last = 1;
                end
                default: begin
                    foreach (live[i]) live[i] = 0;
                end
            endcase
        endfunction

        function void check_square(t_square got);
            t_square want;
            squares_seen++;
            if (pending_squares.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected square x=%0d y=%0d", got.rect_x, got.rect_y);
                return;
            end
            want = pending_squares.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("square %0d: exp x=%0d y=%0d s=%0d rgb=%h%h%h a=%0d l=%0d, got x=%0d y=%0d s=%0d rgb=%h%h%h a=%0d l=%0d",
                        squares_seen, want.rect_x, want.rect_y, want.rect_side,
                        want.red, want.green, want.blue, want.faded_alpha, want.last,
                        got.rect_x, got.rect_y, got.rect_side,
                        got.red, got.green, got.blue, got.faded_alpha, got.last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic signed [15:0] i_vel_x;
    logic signed [15:0] i_vel_y;
    logic [15:0]        i_life_time;
    logic [7:0]         i_dot_size;
    logic signed [15:0] i_fall_accel;
    logic [31:0]        i_colour_rgba;
    logic [15:0]        i_time_step;
    logic               o_valid;
    logic               i_stall;
    logic signed [11:0] o_rect_x;
    logic signed [11:0] o_rect_y;
    logic [3:0]         o_rect_side;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic [7:0]         o_faded_alpha;
    logic               o_last;

    particle_pool_integrator_top i_dut (.*);

    particle_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  requests_sent;
    int  renders_sent;
    longint cycle_count;
    bit  stimulus_done;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("particle_pool_integrator_top: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_square('{o_rect_x, o_rect_y, o_rect_side, o_red, o_green,
                                 o_blue, o_faded_alpha, o_last});
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_request random_request(t_func f);
        t_request r;
        r.func = f;
        r.pos_x = $urandom;
        r.pos_y = $urandom;
        r.vel_x = $urandom;
        r.vel_y = $urandom;
        r.life_time = $urandom;
        r.dot_size = $urandom;
        r.fall_accel = $urandom;
        r.colour = $urandom;
        r.time_step = $urandom;
        if ($urandom_range(3) != 0) begin
            r.pos_x = $signed(16'($urandom_range(0, 1600))) - 16'sd800;
            r.vel_x = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            r.time_step = $urandom_range(0, 4000);
        end
        return r;
    endfunction

    task automatic send_request(t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_func <= r.func;
        i_pos_x <= r.pos_x;
        i_pos_y <= r.pos_y;
        i_vel_x <= r.vel_x;
        i_vel_y <= r.vel_y;
        i_life_time <= r.life_time;
        i_dot_size <= r.dot_size;
        i_fall_accel <= r.fall_accel;
        i_colour_rgba <= r.colour;
        i_time_step <= r.time_step;
        do @(posedge i_clk); while (o_stall);
        board.note_request(r);
        requests_sent++;
        if (r.func == FN_RENDER) renders_sent++;
    endtask

    task automatic send_pattern(int emits);
        for (int k = 0; k < emits; k++) send_request(random_request(FN_EMIT));
        for (int k = 0; k < 2; k++) begin
            send_request(random_request(FN_TICK));
            send_request(random_request(FN_RENDER));
        end
    endtask

    initial begin
        t_request r;
        board = new();
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        requests_sent = 0;
        renders_sent = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_func = FN_CLEAR;
        i_pos_x = 0;
        i_pos_y = 0;
        i_vel_x = 0;
        i_vel_y = 0;
        i_life_time = 0;
        i_dot_size = 0;
        i_fall_accel = 0;
        i_colour_rgba = 0;
        i_time_step = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(random_request(FN_RENDER));
        r = random_request(FN_EMIT);
        r.pos_x = 16'sh7fff; r.pos_y = 16'sh8000; r.vel_x = 16'sh7fff;
        r.vel_y = 16'sh8000; r.life_time = 16'hffff; r.dot_size = 8'hff;
        r.fall_accel = 16'sh8000; r.colour = 32'hffffffff;
        send_request(r);
        r.pos_x = 16'sh8000; r.pos_y = 16'sh7fff; r.vel_x = 16'sh8000;
        r.vel_y = 16'sh7fff; r.fall_accel = 16'sh7fff; r.colour = 32'h0;
        r.dot_size = 8'h0;
        send_request(r);
        r = random_request(FN_EMIT);
        r.life_time = 0;
        send_request(r);
        r = random_request(FN_EMIT);
        r.life_time = 16'd100;
        r.dot_size = 8'h10;
        send_request(r);
        send_request(random_request(FN_RENDER));
        r = random_request(FN_TICK);
        r.time_step = 16'hffff;
        send_request(r);
        send_request(random_request(FN_RENDER));
        r = random_request(FN_EMIT);
        r.life_time = 16'h8000;
        send_request(r);
        send_request(r);
        r = random_request(FN_TICK);
        r.time_step = 16'h4000;
        send_request(r);
        send_request(random_request(FN_RENDER));
        r.time_step = 16'h0;
        send_request(r);
        r = random_request(FN_TICK);
        r.time_step = 16'h4000;
        send_request(r);
        send_request(random_request(FN_RENDER));
        send_request(random_request(FN_CLEAR));
        send_request(random_request(FN_RENDER));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (phase == 2) begin
                for (int k = 0; k < 3; k++) send_request(random_request(FN_EMIT));
                hold_off_cycles = 400;
                send_request(random_request(FN_RENDER));
                send_pattern(0);
            end
            while (requests_sent < 30 + 35 * (phase + 1)) begin
                case ($urandom_range(9))
                    0: send_request(random_request(FN_CLEAR));
                    1, 2, 3: send_pattern($urandom_range(1, 5));
                    4: send_pattern(0);
                    default: send_request(random_request(t_func'($urandom_range(3))));
                endcase
            end
        end
        while (board.emit_ptr != 0) send_request(random_request(FN_EMIT));
        send_request(random_request(FN_RENDER));
        i_valid <= 0;
        recv_stall_pct = 0;

        while (board.pending_squares.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d requests (%0d renders), %0d squares checked",
                 requests_sent, renders_sent, board.squares_seen);
        $display("under idle, stall, long hold-off and full-pool wrap");
        if (board.mismatches == 0 && board.pending_squares.size() == 0) begin
            $display("particle_pool_integrator_top: match");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("particle_pool_integrator_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/ppi_pkg.sv
rtl/ppi_ram.sv
rtl/ppi_div.sv
rtl/particle_pool_integrator_top.sv
test/tb_particle_pool_integrator_top.sv
